// ===== sv/svs_pkg.sv =====
// Package for the skeletal vertex skinning block: widths, codes, state type.
// No dependencies.
`default_nettype none
package svs_pkg;
    localparam int MaxBonesDefault = 64;
    localparam int PosW  = 32;
    localparam int IdxW  = 6;
    localparam int BiasW = 17;
    localparam int SumW  = 48;
    localparam int JointW = 7 * 32;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_WEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_C, ST_D, ST_R, ST_ACC, ST_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic ld_c;
        logic ld_d;
        logic ld_r;
        logic acc;
        logic emit;
    } t_cmd;

    // Saturate signed 32-bit to +-1.0 in Q1.30.
    function automatic logic signed [31:0] sat_rot(input logic signed [31:0] v);
        logic signed [31:0] lim;
        lim = 32'sh4000_0000;
        if (v > lim) return lim;
        else if (v < -lim) return -lim;
        else return v;
    endfunction
endpackage
`default_nettype wire

// ===== sv/skeletal_vertex_skinning.sv =====
// Skeletal vertex skinning, top level.
// Load item: input ready again on the next cycle.
// Weight item: RAM read, cross product, second cross product, sum, bias
// accumulate and, for a last item, emit to the result register; input ready
// again once back in idle, later while a last weight waits on a full result.
// Synchronous active-low reset clears control and sums; bone table is not cleared.
`default_nettype none
module skeletal_vertex_skinning #(
    parameter int MAX_BONES = svs_pkg::MaxBonesDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // bone_index, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w, bias
    input  wire logic [247:0] s_axis_tdata,
    // func
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vert_x, vert_y, vert_z
    output logic [95:0]       m_axis_tdata
);
    import svs_pkg::*;
    t_cmd cmd;
    logic use_w, last_w, r_ov;
    logic signed [31:0] vx, vy, vz;

    svs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_weight(s_axis_tuser == FUNC_WEIGHT),
        .i_use(use_w), .i_last(last_w),
        .i_out_busy(r_ov && !m_axis_tready),
        .o_ready(s_axis_tready), .o_cmd(cmd)
    );

    svs_dp #(.MAX_BONES(MAX_BONES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_func(s_axis_tuser), .i_idx(s_axis_tdata[5:0]),
        .i_px(s_axis_tdata[37:6]), .i_py(s_axis_tdata[69:38]),
        .i_pz(s_axis_tdata[101:70]), .i_rx(s_axis_tdata[133:102]),
        .i_ry(s_axis_tdata[165:134]), .i_rz(s_axis_tdata[197:166]),
        .i_rw(s_axis_tdata[229:198]), .i_bias(s_axis_tdata[246:230]),
        .i_last(s_axis_tlast),
        .o_use(use_w), .o_last(last_w), .o_vx(vx), .o_vy(vy), .o_vz(vz)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (cmd.emit) r_ov <= 1'b1;
        else if (m_axis_tready) r_ov <= 1'b0;
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {vz, vy, vx};

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_ov || m_axis_tready)) else $error("result overwritten");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.ld_c, cmd.ld_d, cmd.ld_r, cmd.acc, cmd.emit}))
        else $error("commands overlap");
    a_c_then_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ld_c |=> cmd.ld_d) else $error("sequence broken");
endmodule
`default_nettype wire

// ===== sv/svs_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module svs_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/svs_ctrl.sv =====
// Controller FSM for the skinning block.
// Depends on svs_pkg.
`default_nettype none
module svs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_weight,
    input  wire logic          i_use,
    input  wire logic          i_last,
    input  wire logic          i_out_busy,
    output logic               o_ready,
    output svs_pkg::t_cmd      o_cmd
);
    import svs_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no transfer while reset is held
                o_ready = i_rst_n;
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    if (i_weight) n_state = ST_READ;
                end
            end
            ST_READ: n_state = i_use ? ST_C : ST_OUT;
            ST_C: begin
                o_cmd.ld_c = 1'b1;
                n_state = ST_D;
            end
            ST_D: begin
                o_cmd.ld_d = 1'b1;
                n_state = ST_R;
            end
            ST_R: begin
                o_cmd.ld_r = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_last) n_state = ST_IDLE;
                else if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/svs_dp.sv =====
// Datapath: bone table RAM, quaternion rotation, bias scale, accumulator.
// Depends on svs_pkg and svs_ram.
`default_nettype none
module svs_dp #(
    parameter int MAX_BONES = svs_pkg::MaxBonesDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire svs_pkg::t_cmd                i_cmd,
    input  wire logic                         i_func,
    input  wire logic [svs_pkg::IdxW-1:0]     i_idx,
    input  wire logic signed [31:0]           i_px, i_py, i_pz,
    input  wire logic signed [31:0]           i_rx, i_ry, i_rz, i_rw,
    input  wire logic [svs_pkg::BiasW-1:0]    i_bias,
    input  wire logic                         i_last,
    output logic                              o_use,
    output logic                              o_last,
    output logic signed [31:0]                o_vx, o_vy, o_vz
);
    import svs_pkg::*;
    // the 6-bit index never reaches past 64 entries
    localparam int TabD = (MAX_BONES < 64) ? MAX_BONES : 64;
    localparam int AW = (TabD > 1) ? $clog2(TabD) : 1;

    logic r_use, r_last;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic [16:0] r_b;
    logic [AW-1:0] r_addr;
    logic valid_idx;
    logic [JointW-1:0] wdata, rdata;

    assign valid_idx = ({3'b0, i_idx} < 9'(MAX_BONES));
    assign o_use = r_use;
    assign o_last = r_last;
    assign wdata = {i_px, i_py, i_pz, sat_rot(i_rx), sat_rot(i_ry), sat_rot(i_rz),
                    sat_rot(i_rw)};

    svs_ram #(.W(JointW), .D(1 << AW)) u_tab (
        .i_clk(i_clk),
        .i_we(i_cmd.cap && i_func == FUNC_LOAD && valid_idx),
        .i_waddr(i_idx[AW-1:0]), .i_wdata(wdata),
        .i_raddr(r_addr), .o_rdata(rdata)
    );

    logic signed [31:0] jx, jy, jz, qx, qy, qz, qw;
    assign {jx, jy, jz, qx, qy, qz, qw} = rdata;

    // capture item fields; only a weight item with a valid index sets use
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_use <= (i_func == FUNC_WEIGHT) && valid_idx;
            r_last <= i_last;
            r_vx <= i_px; r_vy <= i_py; r_vz <= i_pz;
            r_b <= (i_bias > 17'd65536) ? 17'd65536 : i_bias;
            r_addr <= i_idx[AW-1:0];
        end
    end

    // c = q x v, saturated to +-(2^32-1)
    function automatic logic signed [33:0] crs_c(input logic signed [31:0] a, b, c, d);
        logic signed [63:0] p0, p1;
        logic signed [64:0] t;
        logic signed [34:0] s;
        p0 = a * c;
        p1 = b * d;
        t = 65'(p0) - 65'(p1);
        s = 35'(t >>> 30);
        if (s > 35'sh0_FFFF_FFFF) return 34'sh0_FFFF_FFFF;
        else if (s < -35'sh0_FFFF_FFFF) return -34'sh0_FFFF_FFFF;
        else return s[33:0];
    endfunction

    function automatic logic signed [35:0] crs_d(input logic signed [31:0] a, b,
                                                  input logic signed [33:0] c, d);
        logic signed [65:0] p0, p1;
        logic signed [66:0] t;
        p0 = a * c;
        p1 = b * d;
        t = 67'(p0) - 67'(p1);
        return 36'(t >>> 30);
    endfunction

    // w * c scaled back to Q16.16
    function automatic logic signed [34:0] mul_e(input logic signed [31:0] a,
                                                  input logic signed [33:0] c);
        logic signed [65:0] p;
        p = a * c;
        return 35'(p >>> 30);
    endfunction

    logic signed [33:0] r_cx, r_cy, r_cz;
    logic signed [35:0] r_dx, r_dy, r_dz;
    logic signed [34:0] r_ex, r_ey, r_ez;
    logic signed [36:0] r_sx, r_sy, r_sz;
    logic signed [SumW-1:0] r_acx, r_acy, r_acz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_c) begin
            r_cx <= crs_c(qy, qz, r_vz, r_vy);
            r_cy <= crs_c(qz, qx, r_vx, r_vz);
            r_cz <= crs_c(qx, qy, r_vy, r_vx);
        end
        if (i_cmd.ld_d) begin
            r_dx <= crs_d(qy, qz, r_cz, r_cy);
            r_dy <= crs_d(qz, qx, r_cx, r_cz);
            r_dz <= crs_d(qx, qy, r_cy, r_cx);
            r_ex <= mul_e(qw, r_cx);
            r_ey <= mul_e(qw, r_cy);
            r_ez <= mul_e(qw, r_cz);
        end
        if (i_cmd.ld_r) begin
            r_sx <= 37'(r_vx) + 37'(2 * 37'(r_ex)) + 37'(2 * 37'(r_dx)) + 37'(jx);
            r_sy <= 37'(r_vy) + 37'(2 * 37'(r_ey)) + 37'(2 * 37'(r_dy)) + 37'(jy);
            r_sz <= 37'(r_vz) + 37'(2 * 37'(r_ez)) + 37'(2 * 37'(r_dz)) + 37'(jz);
        end
    end

    function automatic logic signed [SumW-1:0] acc48(input logic signed [SumW-1:0] a,
                                                      input logic signed [36:0] r,
                                                      input logic [16:0] b);
        logic signed [54:0] p;
        logic signed [49:0] s;
        p = 55'(r) * $signed({38'd0, b});
        s = 50'(a) + 50'(p >>> 16);
        if (s > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        else if (s < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
        else return s[SumW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] a);
        if (a > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        else if (a < -48'sh0000_8000_0000) return 32'sh8000_0000;
        else return a[31:0];
    endfunction

    // vertex sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acx <= '0; r_acy <= '0; r_acz <= '0;
        end else if (i_cmd.acc) begin
            r_acx <= acc48(r_acx, r_sx, r_b);
            r_acy <= acc48(r_acy, r_sy, r_b);
            r_acz <= acc48(r_acz, r_sz, r_b);
        end else if (i_cmd.emit) begin
            r_acx <= '0; r_acy <= '0; r_acz <= '0;
        end
        if (i_cmd.emit) begin
            o_vx <= sat32(r_acx); o_vy <= sat32(r_acy); o_vz <= sat32(r_acz);
        end
    end
endmodule
`default_nettype wire
